// ===== rtl/pli_pkg.sv =====
// Shared types and constants for the plane/line intersection block.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
`default_nettype none
package pli_pkg;
    localparam int FRAC_DEF = 16;
    // Quotient bits resolved by the divider; larger quotients saturate.
    localparam int QB       = 33;
    localparam int CW       = 64 + QB;
    localparam int QDEPTH   = 8;
    localparam int QPTR_W   = 3;
    localparam int QCNT_W   = 4;
    localparam int FCNT_W   = 3;
    localparam logic [31:0] TOL_RESET = 32'd4295;
    localparam logic ADDR_TOL = 1'b0;

    // Classified word passed from front to back through the queue.
    typedef struct packed {
        logic                  par;
        logic                  big;
        logic                  neg;
        logic [63:0]           num_mag;
        logic [63:0]           den_mag;
        logic [2:0][31:0]      p;
        logic [2:0][31:0]      d;
    } t_qent;
endpackage
`default_nettype wire

// ===== rtl/pli_front.sv =====
// Front part: dot products, magnitudes and parallel/overflow classification.
// Depends on pli_pkg. Free running; the top level meters input by credit.
`timescale 1ns / 1ps
`default_nettype none
module pli_front #(
    parameter int FRAC_BITS = pli_pkg::FRAC_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_acc,
    input  wire logic signed [31:0]      i_n [3],
    input  wire logic signed [31:0]      i_p [3],
    input  wire logic signed [31:0]      i_d [3],
    input  wire logic signed [31:0]      i_off,
    input  wire logic [31:0]             i_tol,
    output logic                         o_push,
    output pli_pkg::t_qent               o_ent,
    output logic [pli_pkg::FCNT_W-1:0]   o_cnt
);
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [63:0] r_nd [3];
    logic signed [63:0] r_np [3];
    logic signed [31:0] r_off;
    logic [2:0][31:0]   r_p1, r_d1, r_p2, r_d2, r_p3, r_d3;
    logic signed [65:0] r_den, r_num;
    logic [63:0]        r_den_mag, r_num_mag;
    logic               r_den_neg, r_num_neg;
    pli_pkg::t_qent     r_ent;
    logic signed [65:0] n_den, n_num;
    logic [pli_pkg::CW-1:0] w_num_sh, w_den_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_nd[i] <= i_n[i] * i_d[i];
            r_np[i] <= i_n[i] * i_p[i];
            r_p1[i] <= i_p[i];
            r_d1[i] <= i_d[i];
        end
        r_off <= i_off;
    end

    always_comb begin
        n_den = 66'(r_nd[0]) + 66'(r_nd[1]) + 66'(r_nd[2]);
        n_num = (66'(r_off) <<< FRAC_BITS) - (66'(r_np[0]) + 66'(r_np[1]) + 66'(r_np[2]));
    end

    always_ff @(posedge i_clk) begin
        r_den <= n_den;
        r_num <= n_num;
        r_p2  <= r_p1;
        r_d2  <= r_d1;
    end

    // Magnitudes fit in 64 bits: |n.d| and |D - n.p| stay below 2^64.
    always_ff @(posedge i_clk) begin
        r_den_neg <= r_den[65];
        r_num_neg <= r_num[65];
        r_den_mag <= r_den[65] ? 64'(-r_den) : r_den[63:0];
        r_num_mag <= r_num[65] ? 64'(-r_num) : r_num[63:0];
        r_p3      <= r_p2;
        r_d3      <= r_d2;
    end

    assign w_num_sh = {{pli_pkg::QB{1'b0}}, r_num_mag} << FRAC_BITS;
    assign w_den_sh = {r_den_mag, {pli_pkg::QB{1'b0}}};

    always_ff @(posedge i_clk) begin
        r_ent.par     <= r_den_mag <= {32'd0, i_tol};
        r_ent.big     <= w_num_sh >= w_den_sh;
        r_ent.neg     <= r_den_neg ^ r_num_neg;
        r_ent.num_mag <= r_num_mag;
        r_ent.den_mag <= r_den_mag;
        r_ent.p       <= r_p3;
        r_ent.d       <= r_d3;
    end

    assign o_push = r_v4;
    assign o_ent  = r_ent;
    assign o_cnt  = pli_pkg::FCNT_W'(r_v1) + pli_pkg::FCNT_W'(r_v2)
                  + pli_pkg::FCNT_W'(r_v3) + pli_pkg::FCNT_W'(r_v4);
endmodule
`default_nettype wire

// ===== rtl/pli_queue.sv =====
// Short queue between front and back parts.
// Depends on pli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pli_queue (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire pli_pkg::t_qent          i_ent,
    input  wire logic                    i_pop,
    output logic                         o_nempty,
    output pli_pkg::t_qent               o_head,
    output logic [pli_pkg::QCNT_W-1:0]   o_count
);
    pli_pkg::t_qent r_mem [pli_pkg::QDEPTH];
    logic [pli_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [pli_pkg::QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + pli_pkg::QCNT_W'(i_push) - pli_pkg::QCNT_W'(i_pop);
        end
    end

    assign o_nempty = r_count != '0;
    assign o_head   = r_mem[r_rd];
    assign o_count  = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != pli_pkg::QCNT_W'(pli_pkg::QDEPTH))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pli_pkg::QCNT_W'(pli_pkg::QDEPTH))
        else $error("queue count out of range");
`endif
endmodule
`default_nettype wire

// ===== rtl/pli_back.sv =====
// Back part: pipelined restoring divider, t*d products, add and clamp.
// Depends on pli_pkg. Whole part holds when the output word is stalled.
`timescale 1ns / 1ps
`default_nettype none
module pli_back #(
    parameter int FRAC_BITS = pli_pkg::FRAC_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_nempty,
    input  wire pli_pkg::t_qent      i_head,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_hit,
    output logic signed [31:0]       o_point_x,
    output logic signed [31:0]       o_point_y,
    output logic signed [31:0]       o_point_z,
    output logic                     o_saturated
);
    localparam int QB = pli_pkg::QB;
    localparam int CW = pli_pkg::CW;
    localparam logic signed [65:0] C_MAX = 66'sd2147483647;
    localparam logic signed [65:0] C_MIN = -66'sd2147483648;

    logic w_en;
    logic           r_v   [QB];
    logic [CW-1:0]  r_rem [QB];
    logic [QB-1:0]  r_q   [QB];
    pli_pkg::t_qent r_ent [QB];

    logic               r_tv, r_tsat, r_tpar;
    logic signed [31:0] r_t;
    logic [2:0][31:0]   r_tp, r_td, r_mp;
    logic               r_mv, r_msat, r_mpar;
    logic signed [63:0] r_prod [3];
    logic               r_ov, r_hit, r_sat;
    logic signed [31:0] r_pt [3];
    logic               n_tsat;
    logic signed [31:0] n_t;
    logic signed [31:0] n_pt [3];
    logic               n_sat;
    logic signed [65:0] w_c;

    assign w_en  = !(r_ov && i_stall);
    assign o_pop = w_en && i_nempty;

    for (genvar j = 0; j < QB; j++) begin : g_div
        logic [CW-1:0]  w_rin;
        logic [QB-1:0]  w_qin;
        pli_pkg::t_qent w_ein;
        logic           w_vin;
        logic [CW-1:0]  w_dsh;
        logic           w_ge;
        if (j == 0) begin : g_first
            assign w_rin = {{QB{1'b0}}, i_head.num_mag} << FRAC_BITS;
            assign w_qin = '0;
            assign w_ein = i_head;
            assign w_vin = i_nempty;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_qin = r_q[j-1];
            assign w_ein = r_ent[j-1];
            assign w_vin = r_v[j-1];
        end
        assign w_dsh = {{QB{1'b0}}, w_ein.den_mag} << (QB - 1 - j);
        assign w_ge  = w_rin >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (w_en) begin
                r_v[j] <= w_vin;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[j] <= w_ge ? w_rin - w_dsh : w_rin;
                r_q[j]   <= w_qin | (QB'(w_ge) << (QB - 1 - j));
                r_ent[j] <= w_ein;
            end
        end
    end

    // Quotient to signed t with saturation.
    always_comb begin
        if (r_ent[QB-1].neg) begin
            n_tsat = r_ent[QB-1].big || r_q[QB-1] > QB'(33'h0_8000_0000);
            n_t    = n_tsat ? 32'sh8000_0000 : 32'(-r_q[QB-1]);
        end else begin
            n_tsat = r_ent[QB-1].big || r_q[QB-1] > QB'(33'h0_7FFF_FFFF);
            n_t    = n_tsat ? 32'sh7FFF_FFFF : r_q[QB-1][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_tv <= r_v[QB-1];
            r_mv <= r_tv;
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t    <= n_t;
            r_tsat <= n_tsat;
            r_tpar <= r_ent[QB-1].par;
            r_tp   <= r_ent[QB-1].p;
            r_td   <= r_ent[QB-1].d;
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= r_t * $signed(r_td[i]);
            end
            r_mp   <= r_tp;
            r_msat <= r_tsat;
            r_mpar <= r_tpar;
        end
    end

    always_comb begin
        n_sat = r_msat;
        w_c   = '0;
        for (int i = 0; i < 3; i++) begin
            // arithmetic shift rounds toward minus infinity
            w_c = 66'($signed(r_mp[i])) + 66'(r_prod[i] >>> FRAC_BITS);
            if (w_c > C_MAX) begin
                n_sat   = 1'b1;
                n_pt[i] = 32'sh7FFF_FFFF;
            end else if (w_c < C_MIN) begin
                n_sat   = 1'b1;
                n_pt[i] = 32'sh8000_0000;
            end else begin
                n_pt[i] = w_c[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit <= !r_mpar;
            r_sat <= !r_mpar && n_sat;
            for (int i = 0; i < 3; i++) begin
                r_pt[i] <= r_mpar ? 32'sd0 : n_pt[i];
            end
        end
    end

    assign o_valid     = r_ov;
    assign o_hit       = r_hit;
    assign o_point_x   = r_pt[0];
    assign o_point_y   = r_pt[1];
    assign o_point_z   = r_pt[2];
    assign o_saturated = r_sat;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_hit |-> r_pt[0] == 0 && r_pt[1] == 0 && r_pt[2] == 0 && !r_sat)
        else $error("parallel result not cleared");
    a_tail_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mv && w_en |=> r_ov)
        else $error("result lost at output");
    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_v[0] == $past(r_v[0]) && r_tv == $past(r_tv))
        else $error("back pipeline moved while held");
`endif
endmodule
`default_nettype wire

// ===== rtl/plane_line_intersection.sv =====
// Pipeline: front registers, queue, 33 divider stages and 3 product/clamp
// stages from accept to output word.
// Throughput: one word per cycle while the output is not stalled; set by the pipelined restoring divider.
// Input is credited against the 8-entry queue; back stalls only on output.
// Reset (synchronous, i_rst_n low): empties pipeline and queue, tolerance 4295.
// Depends on pli_pkg, pli_front, pli_queue, pli_back.
`timescale 1ns / 1ps
`default_nettype none
module plane_line_intersection #(
    parameter int FRAC_BITS = pli_pkg::FRAC_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_normal_x,
    input  wire logic signed [31:0] i_normal_y,
    input  wire logic signed [31:0] i_normal_z,
    input  wire logic signed [31:0] i_plane_offset,
    input  wire logic signed [31:0] i_line_px,
    input  wire logic signed [31:0] i_line_py,
    input  wire logic signed [31:0] i_line_pz,
    input  wire logic signed [31:0] i_line_dx,
    input  wire logic signed [31:0] i_line_dy,
    input  wire logic signed [31:0] i_line_dz,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic signed [31:0]      o_point_x,
    output logic signed [31:0]      o_point_y,
    output logic signed [31:0]      o_point_z,
    output logic                    o_saturated
);
    logic [31:0] r_tol;
    logic        w_acc, w_push, w_pop, w_nempty;
    logic [pli_pkg::FCNT_W-1:0] w_fcnt;
    logic [pli_pkg::QCNT_W-1:0] w_qcnt;
    pli_pkg::t_qent w_ent, w_head;
    logic signed [31:0] w_n [3];
    logic signed [31:0] w_p [3];
    logic signed [31:0] w_d [3];

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pli_pkg::ADDR_TOL) ? r_tol : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= pli_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == pli_pkg::ADDR_TOL) begin
            r_tol <= pwdata;
        end
    end

    // Every word in flight in the front already owns a queue slot.
    assign o_stall = (pli_pkg::QCNT_W'(w_fcnt) + w_qcnt) >= pli_pkg::QCNT_W'(pli_pkg::QDEPTH);
    assign w_acc   = i_valid && !o_stall;

    assign w_n = '{i_normal_x, i_normal_y, i_normal_z};
    assign w_p = '{i_line_px, i_line_py, i_line_pz};
    assign w_d = '{i_line_dx, i_line_dy, i_line_dz};

    pli_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_n     (w_n),
        .i_p     (w_p),
        .i_d     (w_d),
        .i_off   (i_plane_offset),
        .i_tol   (r_tol),
        .o_push  (w_push),
        .o_ent   (w_ent),
        .o_cnt   (w_fcnt)
    );

    pli_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_ent    (w_ent),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_head   (w_head),
        .o_count  (w_qcnt)
    );

    pli_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nempty    (w_nempty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_saturated (o_saturated)
    );
endmodule
`default_nettype wire

// ===== tb/plane_line_intersection_tb.sv =====
// Self-checking bench for plane_line_intersection: predicts each hit/point word
// in exact wide arithmetic, compares it with the output word in order.
// Depends on pli_pkg and the plane_line_intersection RTL.
`timescale 1ns / 1ps

class isect_scoreboard;
    typedef struct {
        logic        hit;
        logic [31:0] px, py, pz;
        logic        sat;
    } isect_word_t;

    isect_word_t pending[$];
    logic [31:0] tolerance;
    int          errors;

    function new();
        tolerance = pli_pkg::TOL_RESET;
        errors = 0;
    endfunction

    // Floor shift of a signed product by FRAC_BITS.
    static function logic signed [127:0] shr_floor(logic signed [127:0] x);
        return x >>> 16;
    endfunction

    static function logic [31:0] clamp(logic signed [127:0] x, ref logic sat);
        if (x > 128'sh7FFFFFFF) begin
            sat = 1'b1;
            return 32'h7FFFFFFF;
        end
        if (x < -128'sh80000000) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return x[31:0];
    endfunction

    function void note_query(logic signed [31:0] n[3], logic signed [31:0] off,
                             logic signed [31:0] p[3], logic signed [31:0] d[3]);
        isect_word_t w;
        logic signed [127:0] den, num, t, c;
        logic [127:0] den_mag, num_mag, q;
        logic sat;
        den = 0;
        num = $signed(128'(off)) <<< 16;
        for (int i = 0; i < 3; i++) begin
            den += $signed(128'(n[i])) * $signed(128'(d[i]));
            num -= $signed(128'(n[i])) * $signed(128'(p[i]));
        end
        den_mag = den < 0 ? -den : den;
        num_mag = num < 0 ? -num : num;
        w = '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0};
        if (den_mag > 128'(tolerance)) begin
            // truncated quotient; divider resolves 33 quotient bits and flags larger ones, so exact compare works
            q = (num_mag << 16) / den_mag;
            sat = 1'b0;
            if ((num < 0) != (den < 0)) begin
                if (q > 128'h80000000) begin
                    sat = 1'b1;
                    t = -128'sh80000000;
                end else t = -$signed(q);
            end else begin
                if (q > 128'h7FFFFFFF) begin
                    sat = 1'b1;
                    t = 128'sh7FFFFFFF;
                end else t = $signed(q);
            end
            w.hit = 1'b1;
            c = $signed(128'(p[0])) + shr_floor(t * $signed(128'(d[0])));
            w.px = clamp(c, sat);
            c = $signed(128'(p[1])) + shr_floor(t * $signed(128'(d[1])));
            w.py = clamp(c, sat);
            c = $signed(128'(p[2])) + shr_floor(t * $signed(128'(d[2])));
            w.pz = clamp(c, sat);
            w.sat = sat;
        end
        pending.push_back(w);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endfunction

    function void check_word(logic hit, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz, logic sat);
        isect_word_t w;
        if (pending.size() == 0) begin
            report("unexpected output word", px, 32'd0);
            return;
        end
        w = pending.pop_front();
        if (hit !== w.hit) report("hit", hit, w.hit);
        if (px !== w.px) report("point_x", px, w.px);
        if (py !== w.py) report("point_y", py, w.py);
        if (pz !== w.pz) report("point_z", pz, w.pz);
        if (sat !== w.sat) report("saturated", sat, w.sat);
    endfunction
endclass

module plane_line_intersection_tb;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 41;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic i_valid, o_stall, o_valid, i_stall;
    logic signed [31:0] i_normal_x, i_normal_y, i_normal_z, i_plane_offset;
    logic signed [31:0] i_line_px, i_line_py, i_line_pz;
    logic signed [31:0] i_line_dx, i_line_dy, i_line_dz;
    logic o_hit, o_saturated;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;

    isect_scoreboard sb;
    int send_idle_pct, stall_pct, cycles;
    bit long_hold;

    plane_line_intersection dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall, or a long hold-off when asked.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                long_hold = 1'b0;
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word(o_hit, o_point_x, o_point_y, o_point_z, o_saturated);
    end

    task automatic apb_write(logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {pli_pkg::ADDR_TOL, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.tolerance = value;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic send_query(logic [31:0] v[10]);
        logic signed [31:0] n[3], p[3], d[3];
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_normal_x, i_normal_y, i_normal_z, i_plane_offset} <= {v[0], v[1], v[2], v[3]};
        {i_line_px, i_line_py, i_line_pz} <= {v[4], v[5], v[6]};
        {i_line_dx, i_line_dy, i_line_dz} <= {v[7], v[8], v[9]};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n = '{v[0], v[1], v[2]};
        p = '{v[4], v[5], v[6]};
        d = '{v[7], v[8], v[9]};
        sb.note_query(n, v[3], p, d);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly sane geometry with occasional full-range or extreme fields.
    function automatic logic [31:0] rand_field(int shape);
        case (shape)
            0: return $urandom();
            1: return $urandom_range(3) == 0 ? 32'h80000000 : 32'h7FFFFFFF;
            2: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
            default: return 32'($signed($urandom_range(65536 * 400)) - 65536 * 200);
        endcase
    endfunction

    task automatic random_run(int count);
        logic [31:0] v[10];
        int shape;
        for (int k = 0; k < count; k++) begin
            shape = $urandom_range(9);
            for (int f = 0; f < 10; f++)
                v[f] = rand_field(shape == 0 ? 0 : shape == 1 ? $urandom_range(1) :
                                  $urandom_range(3, 2));
            // near-parallel: direction tiny so n.d lands near the tolerance
            if ($urandom_range(7) == 0) begin
                v[7] = $urandom_range(3); v[8] = 0; v[9] = 0;
            end
            send_query(v);
        end
        end_burst();
    endtask

    initial begin
        logic [31:0] v[10];
        sb = new();
        i_rst_n <= 1'b0;
        {psel, penable, pwrite} <= 3'b000;
        paddr <= '0; pwdata <= '0;
        i_valid <= 1'b0;
        {i_normal_x, i_normal_y, i_normal_z, i_plane_offset} <= '0;
        {i_line_px, i_line_py, i_line_pz, i_line_dx, i_line_dy, i_line_dz} <= '0;
        send_idle_pct = 0; stall_pct = 0; long_hold = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset tolerance, unit plane z=2, simple lines and extremes
        v = '{0, 0, 32'h10000, 32'h20000, 0, 0, 0, 0, 0, 32'h10000};
        send_query(v);
        v = '{0, 0, 32'h10000, 32'h20000, 32'h30000, 32'hFFFF0000, 0,
              32'h10000, 0, 0};
        send_query(v);                               // parallel
        v = '{0, 0, 32'h10000, 32'hFFFE0000, 5, 7, 32'h40000, 1, 2, 32'hFFFF0000};
        send_query(v);
        v = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        send_query(v);
        v = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 1, 0, 0};
        send_query(v);                               // huge quotient, saturates
        v = '{1, 0, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h10C7, 0, 0};
        send_query(v);                               // n.d exactly at tolerance
        v = '{32'h10000, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0,
              32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        send_query(v);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_query(v);
        end_burst();
        drain();

        apb_write(32'd0);                            // zero tolerance: only denom 0 parallel
        v = '{1, 0, 0, 32'h10000, 0, 0, 0, 1, 0, 0};
        send_query(v);
        v = '{0, 0, 0, 32'h10000, 1, 2, 3, 4, 5, 6};
        send_query(v);
        random_run(60);
        drain();

        apb_write(32'hFFFFFFFF);
        random_run(60);
        drain();

        apb_write(pli_pkg::TOL_RESET);
        send_idle_pct = 73;
        random_run(150);
        drain();                                     // sender pauses for all results

        send_idle_pct = 0; stall_pct = 73;
        apb_write($urandom());
        random_run(150);

        stall_pct = 0; long_hold = 1'b1;             // block fills, input stalls
        random_run(150);
        drain();

        apb_write(32'd65536);
        send_idle_pct = 9; stall_pct = 9;
        random_run(150);
        send_idle_pct = 0; stall_pct = 0;
        random_run(80);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
